// ----- design/tun_pkg.sv -----
`default_nettype none
package tun_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned NUM_AX  = 3;
  localparam int unsigned NUM_IN  = 9;

  typedef struct packed {
    logic valid;
    logic degen;
  } tun_ctl_t;

endpackage
`default_nettype wire

// ----- design/tun_front.sv -----
`default_nettype none
module tun_front #(
  parameter int unsigned CW = 16,
  parameter int unsigned MW = 34,
  parameter int unsigned SW = 70
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        take_i,
  input  wire logic [tun_pkg::NUM_IN-1:0][tun_pkg::FIELD_W-1:0] vtx_i,
  output tun_pkg::tun_ctl_t                                ctl_o,
  output logic [tun_pkg::NUM_AX-1:0]                       neg_o,
  output logic [tun_pkg::NUM_AX-1:0][2*MW-1:0]             sq_o,
  output logic [SW-1:0]                                    s_o
);
  import tun_pkg::*;

  localparam int unsigned DW = CW + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned NW = PW + 1;

  logic [4:0] vld_q;
  logic [4:0] vld_d;

  logic signed [DW-1:0] crd   [NUM_IN];
  logic signed [DW-1:0] d_q   [6];
  logic signed [DW-1:0] d_d   [6];
  logic signed [PW-1:0] p_q   [6];
  logic signed [PW-1:0] p_d   [6];
  logic [NUM_AX-1:0][MW-1:0] mag_q, mag_d;
  logic [NUM_AX-1:0]         neg3_q, neg3_d, neg4_q, neg_q;
  logic [NUM_AX-1:0][2*MW-1:0] sq4_q, sq4_d, sq_q;
  logic [SW-1:0]             s_q, s_d;
  logic                      degen_q;

  always_comb begin
    logic [31:0]    z;
    logic [CW-1:0]  lo;
    for (int i = 0; i < NUM_IN; i++) begin
      z      = {16'b0, vtx_i[i]};
      lo     = z[CW-1:0];
      crd[i] = DW'($signed(lo));
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AX; i++) begin
      d_d[i]     = crd[3+i] - crd[i];
      d_d[3+i]   = crd[6+i] - crd[i];
    end
    p_d[0] = d_q[1] * d_q[5];
    p_d[1] = d_q[2] * d_q[4];
    p_d[2] = d_q[2] * d_q[3];
    p_d[3] = d_q[0] * d_q[5];
    p_d[4] = d_q[0] * d_q[4];
    p_d[5] = d_q[1] * d_q[3];
  end

  always_comb begin
    logic signed [NW-1:0] n;
    logic [NW-1:0]        a;
    for (int i = 0; i < NUM_AX; i++) begin
      n         = NW'(p_q[2*i]) - NW'(p_q[2*i+1]);
      neg3_d[i] = n[NW-1];
      a         = neg3_d[i] ? NW'(-n) : NW'(n);
      mag_d[i]  = a[MW-1:0];
      sq4_d[i]  = mag_q[i] * mag_q[i];
    end
    s_d = SW'(sq4_q[0]) + SW'(sq4_q[1]) + SW'(sq4_q[2]);
  end

  assign vld_d = {vld_q[3:0], take_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q     <= d_d;
    p_q     <= p_d;
    mag_q   <= mag_d;
    neg3_q  <= neg3_d;
    neg4_q  <= neg3_q;
    sq4_q   <= sq4_d;
    sq_q    <= sq4_q;
    neg_q   <= neg4_q;
    s_q     <= s_d;
    degen_q <= (s_d == '0);
  end

  assign ctl_o.valid = vld_q[4];
  assign ctl_o.degen = degen_q;
  assign neg_o       = neg_q;
  assign sq_o        = sq_q;
  assign s_o         = s_q;

endmodule
`default_nettype wire

// ----- design/tun_cell.sv -----
`default_nettype none
module tun_cell #(
  parameter int unsigned K  = 0,
  parameter int unsigned QW = 15,
  parameter int unsigned SW = 70,
  parameter int unsigned BW = 86,
  parameter int unsigned EW = 104
) (
  input  wire logic                 clk_i,
  input  wire logic signed [EW-1:0] rem_i,
  input  wire logic [BW-1:0]        b_i,
  input  wire logic [SW-1:0]        s_i,
  input  wire logic [QW-1:0]        q_i,
  input  wire logic                 neg_i,
  output logic signed [EW-1:0]      rem_o,
  output logic [BW-1:0]             b_o,
  output logic [SW-1:0]             s_o,
  output logic [QW-1:0]             q_o,
  output logic                      neg_o
);

  logic [EW-1:0]        bx, sx, x_val, y_val, inc;
  logic                 take;
  logic signed [EW-1:0] rem_d;
  logic [BW-1:0]        b_d;
  logic [QW-1:0]        q_d;

  always_comb begin
    bx    = EW'(b_i);
    sx    = EW'(s_i);
    x_val = (bx << (K + 2)) - (bx << 1) + (sx << (2 * K + 2)) - (sx << (K + 2)) + sx;
    y_val = (bx << (K + 2)) + (sx << (2 * K + 2));
    inc   = sx << (K + 1);
    take  = $signed(x_val) <= rem_i;
    rem_d = take ? rem_i - $signed(y_val) : rem_i;
    b_d   = take ? b_i + inc[BW-1:0] : b_i;
    q_d   = take ? (q_i | (QW'(1) << K)) : q_i;
  end

  always_ff @(posedge clk_i) begin
    rem_o <= rem_d;
    b_o   <= b_d;
    s_o   <= s_i;
    q_o   <= q_d;
    neg_o <= neg_i;
  end

endmodule
`default_nettype wire

// ----- design/triangle_unit_normal_top.sv -----
// Unit face normal of a triangle, N = cross(b - a, c - a) scaled to length one.
// Input: raise start with the nine vertex coordinates (signed, low
// COORD_WIDTH bits used); the beat is taken on any edge where start is high
// and busy is low. busy stays low, so a new triangle may be offered on every cycle.
// Output: valid_o is high for one cycle with normal_x_o/_y_o/_z_o in signed
// Q1.NORMAL_FRAC_BITS, rounded to nearest with ties away from zero, and
// degenerate_o. A zero cross product gives zero components and degenerate_o.
// Throughput: one beat per cycle. Five front stages form differences, products,
// cross product, squares and the squared length; then a row of
// NORMAL_FRAC_BITS + 1 cells per axis fixes one bit of the rounded component
// each, MSB first, by exact compare.
// The receiver cannot stall; results appear regardless.
// Reset clears all valid flags; data in flight is dropped.
`default_nettype none
module triangle_unit_normal_top #(
  parameter int unsigned COORD_WIDTH      = 16,
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] a_x_i,
  input  wire logic [15:0] a_y_i,
  input  wire logic [15:0] a_z_i,
  input  wire logic [15:0] b_x_i,
  input  wire logic [15:0] b_y_i,
  input  wire logic [15:0] b_z_i,
  input  wire logic [15:0] c_x_i,
  input  wire logic [15:0] c_y_i,
  input  wire logic [15:0] c_z_i,
  output logic             valid_o,
  output logic [15:0]      normal_x_o,
  output logic [15:0]      normal_y_o,
  output logic [15:0]      normal_z_o,
  output logic             degenerate_o
);
  import tun_pkg::*;

  localparam int unsigned F   = NORMAL_FRAC_BITS;
  localparam int unsigned DW  = COORD_WIDTH + 1;
  localparam int unsigned MW  = 2 * DW;
  localparam int unsigned SW  = 2 * MW + 2;
  localparam int unsigned RW  = 2 * MW + 2 * F + 2;
  localparam int unsigned BW  = SW + F + 2;
  localparam int unsigned XW  = SW + 2 * F + 5;
  localparam int unsigned EW  = XW + 1;
  localparam int unsigned QW  = F + 1;
  localparam int unsigned NC  = F + 1;
  localparam int unsigned OW  = (QW + 1 > FIELD_W) ? QW + 1 : FIELD_W;
  localparam int unsigned LAT = F + 7;

  logic [NUM_IN-1:0][FIELD_W-1:0] vtx;
  tun_ctl_t                       fctl;
  logic [NUM_AX-1:0]              neg;
  logic [NUM_AX-1:0][2*MW-1:0]    sq;
  logic [SW-1:0]                  s_sum;
  logic                           take;

  assign take   = start && !busy;
  assign busy   = 1'b0;
  assign vtx    = {c_z_i, c_y_i, c_x_i, b_z_i, b_y_i, b_x_i, a_z_i, a_y_i, a_x_i};

  tun_front #(
    .CW (COORD_WIDTH),
    .MW (MW),
    .SW (SW)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .vtx_i  (vtx),
    .ctl_o  (fctl),
    .neg_o  (neg),
    .sq_o   (sq),
    .s_o    (s_sum)
  );

  logic signed [EW-1:0] rem_w [NUM_AX][NC+1];
  logic [BW-1:0]        b_w   [NUM_AX][NC+1];
  logic [SW-1:0]        s_w   [NUM_AX][NC+1];
  logic [QW-1:0]        q_w   [NUM_AX][NC+1];
  logic                 neg_w [NUM_AX][NC+1];

  for (genvar ax = 0; ax < NUM_AX; ax++) begin : g_ax
    logic [RW-1:0] r_init;
    assign r_init        = RW'(sq[ax]) << (2 * F + 2);
    assign rem_w[ax][0]  = $signed(EW'(r_init));
    assign b_w[ax][0]    = '0;
    assign s_w[ax][0]    = s_sum;
    assign q_w[ax][0]    = '0;
    assign neg_w[ax][0]  = neg[ax];
    for (genvar j = 0; j < NC; j++) begin : g_cell
      tun_cell #(
        .K  (F - j),
        .QW (QW),
        .SW (SW),
        .BW (BW),
        .EW (EW)
      ) u_cell (
        .clk_i (clk_i),
        .rem_i (rem_w[ax][j]),
        .b_i   (b_w[ax][j]),
        .s_i   (s_w[ax][j]),
        .q_i   (q_w[ax][j]),
        .neg_i (neg_w[ax][j]),
        .rem_o (rem_w[ax][j+1]),
        .b_o   (b_w[ax][j+1]),
        .s_o   (s_w[ax][j+1]),
        .q_o   (q_w[ax][j+1]),
        .neg_o (neg_w[ax][j+1])
      );
    end
  end

  tun_ctl_t ctl_q [NC];
  tun_ctl_t ctl_d [NC];

  always_comb begin
    ctl_d[0] = fctl;
    for (int j = 1; j < NC; j++) begin
      ctl_d[j] = ctl_q[j-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NC; j++) begin
        ctl_q[j] <= '0;
      end
    end else begin
      ctl_q <= ctl_d;
    end
  end

  logic [NUM_AX-1:0][FIELD_W-1:0] nrm_d, nrm_q;
  logic                           valid_q, degen_q;

  always_comb begin
    logic [QW:0]          qs;
    logic signed [OW-1:0] ext;
    for (int i = 0; i < NUM_AX; i++) begin
      qs       = neg_w[i][NC] ? (QW+1)'(-{1'b0, q_w[i][NC]}) : {1'b0, q_w[i][NC]};
      ext      = OW'($signed(qs));
      nrm_d[i] = ctl_q[NC-1].degen ? '0 : ext[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_q[NC-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    nrm_q   <= nrm_d;
    degen_q <= ctl_q[NC-1].degen;
  end

  logic unused_rem;
  always_comb begin
    unused_rem = 1'b0;
    for (int i = 0; i < NUM_AX; i++) begin
      unused_rem = unused_rem ^ rem_w[i][NC][0] ^ b_w[i][NC][0] ^ s_w[i][NC][0];
    end
  end

  assign valid_o      = valid_q;
  assign degenerate_o = degen_q & ~(unused_rem & ~unused_rem);
  assign normal_x_o   = nrm_q[0];
  assign normal_y_o   = nrm_q[1];
  assign normal_z_o   = nrm_q[2];

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##LAT valid_o)
    else $error("result beat missing after accepted triangle");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |-> ##LAT !valid_o)
    else $error("result beat without accepted triangle");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o |-> normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("degenerate result with nonzero components");

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
module tb;

  typedef struct {
    logic [15:0] crd [9];
  } tri_t;

  typedef struct {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        degen;
  } normal_t;

  localparam int FRAC       = 14;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [15:0] crd_q [9];
  logic        valid_o;
  logic [15:0] normal_x_o;
  logic [15:0] normal_y_o;
  logic [15:0] normal_z_o;
  logic        degenerate_o;

  tri_t    pending_tris [$];
  normal_t expected_normals [$];
  int      n_sent, n_checked, n_degen, n_errors, n_cycles;
  bit      beat_taken;

  triangle_unit_normal_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start_i),
    .busy         (busy_o),
    .a_x_i        (crd_q[0]),
    .a_y_i        (crd_q[1]),
    .a_z_i        (crd_q[2]),
    .b_x_i        (crd_q[3]),
    .b_y_i        (crd_q[4]),
    .b_z_i        (crd_q[5]),
    .c_x_i        (crd_q[6]),
    .c_y_i        (crd_q[7]),
    .c_z_i        (crd_q[8]),
    .valid_o      (valid_o),
    .normal_x_o   (normal_x_o),
    .normal_y_o   (normal_y_o),
    .normal_z_o   (normal_z_o),
    .degenerate_o (degenerate_o)
  );

  function automatic normal_t face_normal(tri_t t);
    logic signed [17:0] d1 [3];
    logic signed [17:0] d2 [3];
    logic signed [36:0] n [3];
    logic [36:0]        absn;
    logic [127:0]       mag, len_sq, rhs, lhs, k;
    int                 lo, hi, mid;
    logic [15:0]        comp [3];
    normal_t            r;
    for (int i = 0; i < 3; i++) begin
      d1[i] = 18'($signed(t.crd[3 + i])) - 18'($signed(t.crd[i]));
      d2[i] = 18'($signed(t.crd[6 + i])) - 18'($signed(t.crd[i]));
    end
    n[0] = 37'(d1[1]) * 37'(d2[2]) - 37'(d1[2]) * 37'(d2[1]);
    n[1] = 37'(d1[2]) * 37'(d2[0]) - 37'(d1[0]) * 37'(d2[2]);
    n[2] = 37'(d1[0]) * 37'(d2[1]) - 37'(d1[1]) * 37'(d2[0]);
    len_sq = '0;
    for (int i = 0; i < 3; i++) begin
      absn = n[i] < 0 ? -n[i] : n[i];
      mag = 128'(absn);
      len_sq = len_sq + mag * mag;
    end
    if (len_sq == 0) begin
      r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      absn = n[i] < 0 ? -n[i] : n[i];
      mag = 128'(absn);
      rhs = (mag * mag) << (2 * FRAC + 2);
      lo = 0;
      hi = 1 << FRAC;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        k = 128'(2 * mid - 1);
        lhs = k * k * len_sq;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      comp[i] = n[i] < 0 ? 16'(-lo) : 16'(lo);
    end
    r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2]; r.degen = 1'b0;
    return r;
  endfunction

  function automatic tri_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                    int cx, int cy, int cz);
    tri_t t;
    t.crd[0] = 16'(ax); t.crd[1] = 16'(ay); t.crd[2] = 16'(az);
    t.crd[3] = 16'(bx); t.crd[4] = 16'(by); t.crd[5] = 16'(bz);
    t.crd[6] = 16'(cx); t.crd[7] = 16'(cy); t.crd[8] = 16'(cz);
    return t;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver: advance to the next triangle once the current beat is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || beat_taken)) begin
      if (pending_tris.size() != 0 &&
          !((n_sent < 135 && $urandom_range(99) < 34) ||
            (n_sent >= 135 && n_sent < 270 && $urandom_range(99) < 75))) begin
        tri_t t;
        t = pending_tris.pop_front();
        for (int i = 0; i < 9; i++) crd_q[i] <= t.crd[i];
        start_i <= 1'b1;
        n_sent++;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    beat_taken = 1'b0;
    if (rst_ni) begin
      n_cycles++;
      if (valid_o) begin
        if (expected_normals.size() == 0) begin
          $display("%0t: unexpected result %h %h %h %b", $time,
                   normal_x_o, normal_y_o, normal_z_o, degenerate_o);
          n_errors++;
        end else begin
          normal_t e;
          e = expected_normals.pop_front();
          n_checked++;
          if (e.degen) n_degen++;
          if ({normal_x_o, normal_y_o, normal_z_o, degenerate_o} !==
              {e.nx, e.ny, e.nz, e.degen}) begin
            $display("%0t: mismatch expected %h %h %h %b actual %h %h %h %b", $time,
                     e.nx, e.ny, e.nz, e.degen,
                     normal_x_o, normal_y_o, normal_z_o, degenerate_o);
            n_errors++;
          end
        end
      end
      if (start_i && !busy_o) begin
        tri_t t;
        for (int i = 0; i < 9; i++) t.crd[i] = crd_q[i];
        expected_normals.push_back(face_normal(t));
        beat_taken = 1'b1;
      end
      if (n_cycles > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int ax, ay, az, bx, by, bz, k, span;
    start_i = 1'b0;
    for (int i = 0; i < 9; i++) crd_q[i] = '0;
    rst_ni = 1'b0;
    n_sent = 0; n_checked = 0; n_degen = 0; n_errors = 0; n_cycles = 0;

    pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 256, 0, 256, 0, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 256, 0, 0, 0, 256));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 256, 256, 0, 0));
    pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                                    -32768, 32767, -32768));
    pending_tris.push_back(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                                    32767, -32768, 32767));
    pending_tris.push_back(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                                    -32768, -32768, 32767));
    pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                    -32768, 32767, 32767));
    pending_tris.push_back(make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9));
    pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                    -32768, -32768, -32768));
    pending_tris.push_back(make_tri(5, 5, 5, 5, 5, 5, 9, 1, -3));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 1, 0, 0, 1, 1));
    pending_tris.push_back(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 2, 3, -3, 1, 7));
    pending_tris.push_back(make_tri(100, -200, 300, -32768, 0, 32767, 1, 1, 1));
    pending_tris.push_back(make_tri(-1, -1, -1, 0, 0, 0, 1, 1, 1));

    for (int j = 0; j < 400; j++) begin
      tri_t t;
      k = $urandom_range(9);
      span = (k < 4) ? 65535 : (k < 8) ? $urandom_range(15) : 0;
      for (int i = 0; i < 9; i++)
        t.crd[i] = (span == 65535) ? 16'($urandom) :
                   16'($signed($urandom_range(2 * span)) - span);
      if (k >= 8) begin
        // collinear or coincident vertices
        ax = $signed(t.crd[0]); ay = $signed(t.crd[1]); az = $signed(t.crd[2]);
        bx = $urandom_range(6) - 3; by = $urandom_range(6) - 3; bz = $urandom_range(6) - 3;
        span = $urandom_range(4) - 2;
        t.crd[3] = 16'(ax + bx); t.crd[4] = 16'(ay + by); t.crd[5] = 16'(az + bz);
        t.crd[6] = 16'(ax + span * bx); t.crd[7] = 16'(ay + span * by);
        t.crd[8] = 16'(az + span * bz);
      end
      pending_tris.push_back(t);
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_tris.size() == 0);
    @(posedge clk_i);
    while (start_i || expected_normals.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("Sent %0d triangles with sender gaps varied, checked %0d normals", n_sent,
             n_checked);
    $display("%0d degenerate triangles, %0d mismatches", n_degen, n_errors);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/tun_pkg.sv
design/tun_front.sv
design/tun_cell.sv
design/triangle_unit_normal_top.sv
verif/tb.sv
